// File: sv/hvn_pkg.sv
`timescale 1ns / 1ps

package hvn_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_DIM_DEF = 1024;
   localparam int OCTAVES_DEF = 4;

   // Field widths fixed by the interface
   localparam int COORD_W  = 10;
   localparam int SEED_W   = 32;
   localparam int INVF_W   = 24;
   localparam int SCALE_W  = 16;
   localparam int DIM_W    = 11;
   localparam int HEIGHT_W = 41;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;

   // Datapath widths
   localparam int PROD_W = SEED_W + INVF_W + 1;   // noise times inv_frequency
   localparam int SUM_W  = PROD_W + 2;            // octave sum, geometric weights stay below 2x
   localparam int LO_W   = 22;                    // low split of the height before scaling
   localparam int HI_W   = SUM_W - LO_W;
   localparam int A_W    = HI_W + SCALE_W + 1;
   localparam int B_W    = LO_W + SCALE_W;
   localparam int FULL_W = A_W + LO_W;
   localparam int SCALE_SHIFT = 38;
   localparam int R_W    = FULL_W - SCALE_SHIFT;

   // Back-end pipeline depth and queue depth
   localparam int BACK_STAGES = 9;
   localparam int QUEUE_DEPTH = 4;

   // Hash constants
   localparam logic [31:0] HASH_X_MUL = 32'd73856093;
   localparam logic [31:0] HASH_Y_MUL = 32'd19349663;
   localparam logic [31:0] HASH_C1    = 32'd15731;
   localparam logic [31:0] HASH_C2    = 32'd789221;
   localparam logic [31:0] HASH_C3    = 32'd1376312589;
   localparam logic signed [31:0] NOISE_ONE = 32'sh4000_0000;   // 1.0 in Q2.30
   localparam logic signed [SUM_W-1:0] HALF_BIAS = SUM_W'(64'sd1 <<< 46);

   // Register reset values
   localparam logic [SEED_W-1:0]  SEED_RST  = '0;
   localparam logic [INVF_W-1:0]  INVF_RST  = 24'd65536;
   localparam logic [SCALE_W-1:0] SCALE_RST = 16'd256;
   localparam logic [DIM_W-1:0]   DIM_RST   = 11'd1024;

   typedef enum logic [2:0] {
      REG_BASE_SEED     = 3'd0,
      REG_INV_FREQUENCY = 3'd1,
      REG_HEIGHT_SCALE  = 3'd2,
      REG_MAP_WIDTH     = 3'd3,
      REG_MAP_HEIGHT    = 3'd4
   } hvn_reg_type;

   typedef struct packed {
      logic [COORD_W-1:0] x_coord;
      logic [COORD_W-1:0] y_coord;
      logic               in_range;
   } hvn_item_type;

   typedef struct packed {
      logic [DIM_W-1:0] map_width;
      logic [DIM_W-1:0] map_height;
   } hvn_dims_type;

   typedef struct packed {
      logic [SEED_W-1:0]  base_seed;
      logic [INVF_W-1:0]  inv_frequency;
      logic [SCALE_W-1:0] height_scale;
   } hvn_noise_cfg_type;

endpackage

// File: sv/hvn_front.sv
`timescale 1ns / 1ps

module hvn_front #(
   parameter int MAX_DIM = hvn_pkg::MAX_DIM_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [hvn_pkg::COORD_W-1:0]  in_x_coord,
   input  logic [hvn_pkg::COORD_W-1:0]  in_y_coord,
   input  hvn_pkg::hvn_dims_type        dims,
   output logic                         out_valid,
   input  logic                         out_ready,
   output hvn_pkg::hvn_item_type        out_item
);

   localparam int BOUND_W = $clog2(MAX_DIM + 1);
   localparam int CMP_W   = (BOUND_W > hvn_pkg::DIM_W) ? BOUND_W : hvn_pkg::DIM_W;
   localparam logic [CMP_W-1:0] MAX_BOUND = CMP_W'(MAX_DIM);

   logic                  valid_ff;
   hvn_pkg::hvn_item_type item_ff;
   hvn_pkg::hvn_item_type item_in;
   logic [CMP_W-1:0]      width_lim;
   logic [CMP_W-1:0]      height_lim;
   logic                  take;

   // Clamp the map bounds, then classify the point
   always_comb begin
      width_lim  = (CMP_W'(dims.map_width) > MAX_BOUND) ? MAX_BOUND : CMP_W'(dims.map_width);
      height_lim = (CMP_W'(dims.map_height) > MAX_BOUND) ? MAX_BOUND : CMP_W'(dims.map_height);
      item_in.x_coord  = in_x_coord;
      item_in.y_coord  = in_y_coord;
      item_in.in_range = (CMP_W'(in_x_coord) < width_lim) && (CMP_W'(in_y_coord) < height_lim);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

// File: sv/hvn_queue.sv
`timescale 1ns / 1ps

module hvn_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  hvn_pkg::hvn_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hvn_pkg::hvn_item_type out_item
);

   localparam int DEPTH = hvn_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   hvn_pkg::hvn_item_type slot_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff;
   logic [PTR_W-1:0]      rd_ptr_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  push;
   logic                  pop;

   assign in_ready  = (cnt_ff != CNT_W'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_push_only: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + CNT_W'(1)))
      else $error("queue count missed a push");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && !push && cnt_ff == CNT_W'(1)) |=> !out_valid)
      else $error("queue shows an item after the last one left");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");

endmodule

// File: sv/hvn_back.sv
`timescale 1ns / 1ps

module hvn_back #(
   parameter int OCTAVES = hvn_pkg::OCTAVES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  hvn_pkg::hvn_item_type               in_item,
   input  hvn_pkg::hvn_noise_cfg_type          cfg,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [hvn_pkg::HEIGHT_W-1:0] out_height_value,
   output logic                                out_in_range
);

   localparam int STAGES  = hvn_pkg::BACK_STAGES;
   localparam int PROD_W  = hvn_pkg::PROD_W;
   localparam int SUM_W   = hvn_pkg::SUM_W;
   localparam int LO_W    = hvn_pkg::LO_W;
   localparam int HI_W    = hvn_pkg::HI_W;
   localparam int A_W     = hvn_pkg::A_W;
   localparam int B_W     = hvn_pkg::B_W;
   localparam int FULL_W  = hvn_pkg::FULL_W;
   localparam int R_W     = hvn_pkg::R_W;
   localparam int H_W     = hvn_pkg::HEIGHT_W;

   logic [STAGES-1:0] vld_ff;
   logic              rng_ff [STAGES];
   logic              en;

   // Stage 1: coordinate products shared by all octaves
   logic [31:0] xm_ff;
   logic [31:0] ym_ff;
   // Stages 2..6: one lane per octave
   logic [31:0] n2_ff [OCTAVES];
   logic [31:0] n3_ff [OCTAVES];
   logic [31:0] n4_ff [OCTAVES];
   logic [31:0] sq_ff [OCTAVES];
   logic [31:0] t_ff  [OCTAVES];
   logic signed [31:0] noise_ff [OCTAVES];
   logic signed [PROD_W-1:0] prod_ff [OCTAVES];
   // Stages 7..9: sum, scale, result
   logic signed [SUM_W-1:0] h_ff;
   logic signed [A_W-1:0]   a_ff;
   logic [B_W-1:0]          b_ff;
   logic signed [H_W-1:0]   height_ff;

   logic [31:0] n2_in    [OCTAVES];
   logic [31:0] sq_in    [OCTAVES];
   logic [31:0] t_in     [OCTAVES];
   logic signed [31:0] noise_in [OCTAVES];
   logic signed [PROD_W-1:0] prod_in [OCTAVES];
   logic signed [SUM_W-1:0]  h_in;
   logic signed [A_W-1:0]    a_in;
   logic [B_W-1:0]           b_in;
   logic signed [H_W-1:0]    height_in;

   // Whole pipeline advances when the result register is free or being taken
   assign en        = !vld_ff[STAGES-1] || out_ready;
   assign in_ready  = en;
   assign out_valid = vld_ff[STAGES-1];
   assign out_in_range     = rng_ff[STAGES-1];
   assign out_height_value = height_ff;

   always_comb begin
      logic [31:0] n0;
      logic [31:0] p;
      logic signed [SUM_W-1:0] acc;
      logic signed [FULL_W-1:0] full;
      logic signed [R_W-1:0] r;
      n0 = '0;
      p = '0;
      acc = '0;
      for (int i = 0; i < OCTAVES; i++) begin
         n0 = (cfg.base_seed + 32'(i) + xm_ff) ^ ym_ff;
         n2_in[i] = {n0[18:0], 13'b0} ^ n0;
         sq_in[i] = n2_ff[i] * n2_ff[i];
         t_in[i]  = sq_ff[i] * hvn_pkg::HASH_C1 + hvn_pkg::HASH_C2;
         p = n4_ff[i] * t_ff[i] + hvn_pkg::HASH_C3;
         noise_in[i] = hvn_pkg::NOISE_ONE - $signed({1'b0, p[30:0]});
         prod_in[i]  = PROD_W'(noise_ff[i] * $signed({1'b0, cfg.inv_frequency}));
         acc = acc + (SUM_W'(prod_ff[i]) >>> i);
      end
      h_in = (acc + hvn_pkg::HALF_BIAS) >>> 1;
      a_in = A_W'($signed(h_ff[SUM_W-1:LO_W]) * $signed({1'b0, cfg.height_scale}));
      b_in = B_W'(h_ff[LO_W-1:0] * cfg.height_scale);
      full = (FULL_W'(a_ff) <<< LO_W) + $signed({{(FULL_W-B_W){1'b0}}, b_ff});
      r = full[FULL_W-1:hvn_pkg::SCALE_SHIFT];
      // The scaled height never exceeds the output range, so extension is exact
      height_in = rng_ff[STAGES-2] ? H_W'(r) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rng_ff[0] <= in_item.in_range;
         for (int s = 1; s < STAGES; s++) begin
            rng_ff[s] <= rng_ff[s-1];
         end
         xm_ff <= 32'(in_item.x_coord) * hvn_pkg::HASH_X_MUL;
         ym_ff <= 32'(in_item.y_coord) * hvn_pkg::HASH_Y_MUL;
         for (int i = 0; i < OCTAVES; i++) begin
            n2_ff[i]    <= n2_in[i];
            n3_ff[i]    <= n2_ff[i];
            sq_ff[i]    <= sq_in[i];
            n4_ff[i]    <= n3_ff[i];
            t_ff[i]     <= t_in[i];
            noise_ff[i] <= noise_in[i];
            prod_ff[i]  <= prod_in[i];
         end
         h_ff      <= h_in;
         a_ff      <= a_in;
         b_ff      <= b_in;
         height_ff <= height_in;
      end
   end

   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_in_range) |-> (out_height_value == '0))
      else $error("out-of-map result with nonzero height");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (en && vld_ff[STAGES-2]) |=> out_valid)
      else $error("result lost leaving the scale stage");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> (vld_ff == $past(vld_ff)))
      else $error("pipeline moved while stalled");

endmodule

// File: sv/hashed_value_noise_heightmap_core.sv
`timescale 1ns / 1ps

// Terrain height from hashed value noise with an octave sum.
//
// Request channel (req_): one map coordinate per request, x_coord and
// y_coord. Response channel (rsp_): one result per request, in order,
// height_value as signed Q25.16 and in_range. A point outside the map
// returns zero height with in_range clear.
// Configuration is an APB-style port at byte addresses 0x00 base_seed,
// 0x04 inv_frequency, 0x08 height_scale, 0x0C map_width, 0x10 map_height;
// change it only while no request is in flight.
// Throughput: one request per cycle while rsp_ready stays high. A request
// passes the front register, a queue slot and the nine back-end stages
// on its way to the response.
// Reset clears all valid state and loads the register defaults
// (seed 0, inv_frequency 1.0, height_scale 1.0, 1024 by 1024 map).
// When the receiver stalls, the back end holds; the queue keeps filling
// until full, then req_ready drops.
module hashed_value_noise_heightmap_core #(
   parameter int MAX_DIM = hvn_pkg::MAX_DIM_DEF,
   parameter int OCTAVES = hvn_pkg::OCTAVES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [hvn_pkg::COORD_W-1:0]         req_x_coord,
   input  logic [hvn_pkg::COORD_W-1:0]         req_y_coord,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [hvn_pkg::HEIGHT_W-1:0] rsp_height_value,
   output logic                                rsp_in_range,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [hvn_pkg::CSR_AW-1:0]          csr_paddr,
   input  logic [hvn_pkg::CSR_DW-1:0]          csr_pwdata,
   output logic [hvn_pkg::CSR_DW-1:0]          csr_prdata,
   output logic                                csr_pready
);

   logic [hvn_pkg::SEED_W-1:0]  base_seed_ff;
   logic [hvn_pkg::INVF_W-1:0]  inv_frequency_ff;
   logic [hvn_pkg::SCALE_W-1:0] height_scale_ff;
   logic [hvn_pkg::DIM_W-1:0]   map_width_ff;
   logic [hvn_pkg::DIM_W-1:0]   map_height_ff;

   logic                        csr_wr;
   hvn_pkg::hvn_reg_type        csr_sel;

   hvn_pkg::hvn_dims_type       dims;
   hvn_pkg::hvn_noise_cfg_type  noise_cfg;

   logic                        fq_valid;
   logic                        fq_ready;
   hvn_pkg::hvn_item_type       fq_item;
   logic                        qb_valid;
   logic                        qb_ready;
   hvn_pkg::hvn_item_type       qb_item;

   // Register file: always ready, write on the access phase
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_sel    = hvn_pkg::hvn_reg_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_seed_ff     <= hvn_pkg::SEED_RST;
         inv_frequency_ff <= hvn_pkg::INVF_RST;
         height_scale_ff  <= hvn_pkg::SCALE_RST;
         map_width_ff     <= hvn_pkg::DIM_RST;
         map_height_ff    <= hvn_pkg::DIM_RST;
      end else if (csr_wr) begin
         unique case (csr_sel)
            hvn_pkg::REG_BASE_SEED:     base_seed_ff     <= csr_pwdata;
            hvn_pkg::REG_INV_FREQUENCY: inv_frequency_ff <= csr_pwdata[hvn_pkg::INVF_W-1:0];
            hvn_pkg::REG_HEIGHT_SCALE:  height_scale_ff  <= csr_pwdata[hvn_pkg::SCALE_W-1:0];
            hvn_pkg::REG_MAP_WIDTH:     map_width_ff     <= csr_pwdata[hvn_pkg::DIM_W-1:0];
            hvn_pkg::REG_MAP_HEIGHT:    map_height_ff    <= csr_pwdata[hvn_pkg::DIM_W-1:0];
            default: ;   // drop writes to unmapped addresses
         endcase
      end
   end

   // Read back the addressed register; unmapped addresses read zero
   always_comb begin
      unique case (csr_sel)
         hvn_pkg::REG_BASE_SEED:     csr_prdata = base_seed_ff;
         hvn_pkg::REG_INV_FREQUENCY: csr_prdata = hvn_pkg::CSR_DW'(inv_frequency_ff);
         hvn_pkg::REG_HEIGHT_SCALE:  csr_prdata = hvn_pkg::CSR_DW'(height_scale_ff);
         hvn_pkg::REG_MAP_WIDTH:     csr_prdata = hvn_pkg::CSR_DW'(map_width_ff);
         hvn_pkg::REG_MAP_HEIGHT:    csr_prdata = hvn_pkg::CSR_DW'(map_height_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   assign dims.map_width          = map_width_ff;
   assign dims.map_height         = map_height_ff;
   assign noise_cfg.base_seed     = base_seed_ff;
   assign noise_cfg.inv_frequency = inv_frequency_ff;
   assign noise_cfg.height_scale  = height_scale_ff;

   // Front: take the request and mark whether it lies in the map
   hvn_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_x_coord (req_x_coord),
      .in_y_coord (req_y_coord),
      .dims       (dims),
      .out_valid  (fq_valid),
      .out_ready  (fq_ready),
      .out_item   (fq_item)
   );

   // Queue: decouple the front from back-end stalls
   hvn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_item   (fq_item),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_item  (qb_item)
   );

   // Back: hash lanes, octave sum, scale, response register
   hvn_back #(
      .OCTAVES (OCTAVES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (qb_valid),
      .in_ready         (qb_ready),
      .in_item          (qb_item),
      .cfg              (noise_cfg),
      .out_valid        (rsp_valid),
      .out_ready        (rsp_ready),
      .out_height_value (rsp_height_value),
      .out_in_range     (rsp_in_range)
   );

endmodule
